>>> sv/cmac_pkg.sv
package cmac_pkg;

  localparam int unsigned BlkW = 128;
  localparam int unsigned QDepth = 2;
  localparam int unsigned LastRound = 10;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DERIVE,
    B_CHAIN,
    B_FINAL,
    B_OUT
  } back_state_e;

  // One queue entry: an optional chaining block and an optional final block.
  typedef struct packed {
    logic            do_chain;
    logic [BlkW-1:0] chain_blk;
    logic            do_final;
    logic            use_k1;
    logic [BlkW-1:0] final_blk;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    logic     full;
    q_entry_t head;
  } q_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] get_byte(input logic [BlkW-1:0] v, input int unsigned k);
    get_byte = v[BlkW-1-8*k -: 8];
  endfunction

  // Byte k of a block sits at bits 127-8k down to 120-8k; 15-k is ~k on four bits.
  function automatic logic [BlkW-1:0] put_byte(input logic [BlkW-1:0] v,
                                               input logic [3:0] k, input logic [7:0] b);
    logic [6:0] sh;
    sh = {~k, 3'b000};
    put_byte = v | (BlkW'(b) << sh);
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [BlkW-1:0] key_step(input logic [BlkW-1:0] rk, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
          SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    key_step = {n0, n1, n2, n3};
  endfunction

  function automatic logic [BlkW-1:0] aes_round(input logic [BlkW-1:0] s,
                                                input logic [BlkW-1:0] rk, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BlkW-1:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = SBOX[get_byte(s, i + 4*((c+i) & 3))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[BlkW-1-8*k -: 8] = t[k];
    end
    aes_round = r ^ rk;
  endfunction

  function automatic logic [BlkW-1:0] gf_double(input logic [BlkW-1:0] v);
    gf_double = {v[BlkW-2:0], 1'b0} ^ (v[BlkW-1] ? BlkW'(8'h87) : '0);
  endfunction

endpackage

>>> sv/cmac_if.sv
interface cmac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface cmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_high;
  logic [63:0] tag_low;
  modport source (output valid, tag_high, tag_low, input ready);
  modport sink (input valid, tag_high, tag_low, output ready);
endinterface

>>> sv/aes128_cmac_tag_core.sv
// AES-128 CMAC tag generator.
// Message bytes arrive one per transaction on in_i (data_byte qualified by
// byte_present, message_end closing the message). One tag transaction per
// message leaves on out_o. The key is written over the APB port as two
// 64-bit registers: key_high at address 0 and key_low at address 8.
// The front end takes one transaction per cycle while the queue is not full
// and gathers bytes into a 16-byte block; a full block is only handed on
// when a further byte shows it is not the last. Handed-on work waits in a
// two-entry queue while the back end runs an iterative AES core at one round
// per cycle, expanding the round keys alongside. After reset or a key write,
// the subkeys are derived before the first message block is encrypted. A
// pending chaining block is encrypted before the final block of its entry.
// Reset clears the gathered block, the chaining value, the queue and the
// subkey state; the key registers reset to zero.
// When the receiver stalls, the tag waits in the output register; the back
// end holds the next tag and the queue fills before in_i.ready drops.
module aes128_cmac_tag_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmac_in_if.sink     in_i,
  cmac_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cmac_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  logic        wr_en, push, pop;
  q_entry_t    entry;
  q_status_t   qs;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = paddr[3] ? key_lo_q : key_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (wr_en) begin
      if (paddr[3]) key_lo_q <= pwdata;
      else key_hi_q <= pwdata;
    end
  end

  cmac_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (qs.full),
    .push_o   (push),
    .entry_o  (entry)
  );

  cmac_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .status_o (qs)
  );

  cmac_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    ({key_hi_q, key_lo_q}),
    .key_wr_i (wr_en),
    .q_i      (qs),
    .pop_o    (pop),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) qs.full |-> !push)
    else $error("queue overflow");
  // The back end never retires an entry the queue does not hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> qs.valid)
    else $error("queue underflow");
`endif

endmodule

>>> sv/cmac_front.sv
module cmac_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  cmac_in_if.sink          in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output cmac_pkg::q_entry_t entry_o
);
  import cmac_pkg::*;

  logic [4:0]      cnt_q, cnt_d;
  logic [BlkW-1:0] blk_q, blk_d;
  logic            acc, active, chain;
  logic [4:0]      base_cnt, cnt1;
  logic [BlkW-1:0] base_blk, blk1;

  assign in_i.ready = !q_full_i;
  assign acc    = in_i.valid && in_i.ready;
  assign active = acc && (in_i.byte_present || in_i.message_end);

  always_comb begin
    chain    = in_i.byte_present && (cnt_q == 5'd16);
    base_blk = chain ? '0 : blk_q;
    base_cnt = chain ? 5'd0 : cnt_q;
    blk1     = base_blk;
    cnt1     = base_cnt;
    if (in_i.byte_present) begin
      blk1 = put_byte(base_blk, base_cnt[3:0], in_i.data_byte);
      cnt1 = base_cnt + 5'd1;
    end
    entry_o.do_chain  = chain;
    entry_o.chain_blk = blk_q;
    entry_o.do_final  = in_i.message_end;
    entry_o.use_k1    = (cnt1 == 5'd16);
    // A short final block gets the one-then-zeros pad.
    entry_o.final_blk = (cnt1 == 5'd16) ? blk1 : put_byte(blk1, cnt1[3:0], 8'h80);
    push_o = active && (chain || in_i.message_end);
    cnt_d  = in_i.message_end ? 5'd0 : cnt1;
    blk_d  = in_i.message_end ? '0 : blk1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
      blk_q <= '0;
    end else if (active) begin
      cnt_q <= cnt_d;
      blk_q <= blk_d;
    end
  end

endmodule

>>> sv/cmac_queue.sv
module cmac_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cmac_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output cmac_pkg::q_status_t status_o
);
  import cmac_pkg::*;

  q_entry_t   mem_q [QDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign status_o.valid = (cnt_q != 2'd0);
  assign status_o.full  = (cnt_q == 2'(QDepth));
  assign status_o.head  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> sv/cmac_back.sv
module cmac_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [127:0]        key_i,
  input  logic                key_wr_i,
  input  cmac_pkg::q_status_t q_i,
  output logic                pop_o,
  cmac_out_if.source          out_o
);
  import cmac_pkg::*;

  back_state_e     state_q, state_d;
  logic [BlkW-1:0] s_q, s_d, rk_q, rk_d, x_q, x_d, k1_q, k2_q, tag_q;
  logic [3:0]      rnd_q, rnd_d;
  logic            ready_q, chained_q, ov_q;
  logic            aes_done, start, load_out;
  logic [BlkW-1:0] start_blk, rk_n, rnd_out;

  assign aes_done = (rnd_q == 4'(LastRound));
  assign rk_n     = key_step(rk_q, rcon(rnd_q));
  assign rnd_out  = aes_round(s_q, rk_n, aes_done);
  assign load_out = (state_q == B_OUT) && (!ov_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_i.valid) begin
          if (!ready_q) state_d = B_DERIVE;
          else if (q_i.head.do_chain && !chained_q) state_d = B_CHAIN;
          else state_d = B_FINAL;
        end
      end
      B_DERIVE: if (aes_done) state_d = B_IDLE;
      B_CHAIN:  if (aes_done) state_d = B_IDLE;
      B_FINAL:  if (aes_done) state_d = B_OUT;
      B_OUT:    if (load_out) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    start     = (state_q == B_IDLE) && q_i.valid;
    start_blk = '0;
    if (ready_q) begin
      if (q_i.head.do_chain && !chained_q) begin
        start_blk = x_q ^ q_i.head.chain_blk;
      end else begin
        start_blk = x_q ^ q_i.head.final_blk ^ (q_i.head.use_k1 ? k1_q : k2_q);
      end
    end
    s_d   = start ? (start_blk ^ key_i) : rnd_out;
    rk_d  = start ? key_i : rk_n;
    rnd_d = start ? 4'd1 : rnd_q + 4'd1;
    x_d   = x_q;
    pop_o = 1'b0;
    if (aes_done && state_q == B_CHAIN) begin
      x_d   = rnd_out;
      pop_o = !q_i.head.do_final;
    end
    if (aes_done && state_q == B_FINAL) begin
      x_d   = '0;
      pop_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      ready_q   <= 1'b0;
      chained_q <= 1'b0;
      ov_q      <= 1'b0;
      rnd_q     <= 4'd0;
      x_q       <= '0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      if (start || state_q == B_DERIVE || state_q == B_CHAIN || state_q == B_FINAL) begin
        rnd_q <= rnd_d;
      end
      if (key_wr_i) ready_q <= 1'b0;
      else if (state_q == B_DERIVE && aes_done) ready_q <= 1'b1;
      if (state_q == B_CHAIN && aes_done) chained_q <= q_i.head.do_final;
      else if (state_q == B_FINAL && aes_done) chained_q <= 1'b0;
      if (load_out) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start || state_q == B_DERIVE || state_q == B_CHAIN || state_q == B_FINAL) begin
      s_q  <= s_d;
      rk_q <= rk_d;
    end
    if (state_q == B_DERIVE && aes_done) begin
      k1_q <= gf_double(rnd_out);
      k2_q <= gf_double(gf_double(rnd_out));
    end
    if (load_out) tag_q <= s_q;
  end

  assign out_o.valid    = ov_q;
  assign out_o.tag_high = tag_q[127:64];
  assign out_o.tag_low  = tag_q[63:0];

endmodule
